// File: rtl/sle_pkg.sv
package sle_pkg;

    // Default sizing
    localparam int LINE_BYTES_DEF = 20;
    localparam int POOL_SLOTS_DEF = 2;

    // Field widths
    localparam int BYTE_W    = 8;
    localparam int KIND_W    = 2;
    localparam int LEN_OUT_W = 5;

    // Special characters
    localparam logic [BYTE_W-1:0] CH_CTRL_Z    = 8'h1A;
    localparam logic [BYTE_W-1:0] CH_NEWLINE   = 8'h0A;
    localparam logic [BYTE_W-1:0] CH_BACKSPACE = 8'h08;
    localparam logic [BYTE_W-1:0] CH_BANG      = 8'h21;

    // Result kinds
    localparam logic [KIND_W-1:0] KIND_ECHO = 2'd0;
    localparam logic [KIND_W-1:0] KIND_CHAR = 2'd1;
    localparam logic [KIND_W-1:0] KIND_END  = 2'd2;

    // Input actions
    localparam logic ACT_BYTE    = 1'b0;
    localparam logic ACT_RELEASE = 1'b1;

    // Address width of a store, at least one bit
    function automatic int addr_w(input int depth);
        addr_w = (depth > 1) ? $clog2(depth) : 1;
    endfunction

    // Controller states
    typedef enum logic [4:0] {
        ST_IDLE   = 5'b00001,
        ST_DECODE = 5'b00010,
        ST_CHARS  = 5'b00100,
        ST_END    = 5'b01000,
        ST_ECHO   = 5'b10000
    } state_t;

    // Controller to datapath
    typedef struct packed {
        logic capture;
        logic dec_pending;
        logic take_slot;
        logic set_bang;
        logic clear_len;
        logic dec_len;
        logic store_char;
        logic load_char;
        logic load_end;
        logic load_echo;
        logic end_last;
    } cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic is_release;
        logic no_slot;
        logic is_ctrl_z;
        logic is_newline;
        logic is_backspace;
        logic len_zero;
        logic len_full;
        logic char_last;
        logic out_free;
    } status_t;

endpackage

// File: rtl/sle_ram.sv
module sle_ram
    import sle_pkg::*;
#(
    parameter int WIDTH = BYTE_W,
    parameter int DEPTH = LINE_BYTES_DEF - 1
) (
    input  logic                      aclk,
    input  logic                      wr_en,
    input  logic [addr_w(DEPTH)-1:0]  wr_addr,
    input  logic [WIDTH-1:0]          wr_data,
    input  logic [addr_w(DEPTH)-1:0]  rd_addr,
    output logic [WIDTH-1:0]          rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // One write port, one registered read port
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

// File: rtl/sle_ctrl.sv
module sle_ctrl
    import sle_pkg::*;
(
    input  logic    aclk,
    input  logic    aresetn,
    input  logic    s_valid,
    output logic    s_ready,
    input  status_t status,
    output cmd_t    cmd
);

    state_t state_reg;
    state_t state_next;
    logic   is_other;

    // Ordinary byte (not one of the control characters)
    assign is_other = !status.is_ctrl_z && !status.is_newline && !status.is_backspace;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    assign s_ready = (state_reg == ST_IDLE);

    // Next state and commands
    always_comb begin
        cmd        = '0;
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    cmd.capture = 1'b1;
                    state_next  = ST_DECODE;
                end
            end
            ST_DECODE: begin
                if (status.is_release) begin
                    cmd.dec_pending = 1'b1;
                    state_next      = ST_IDLE;
                end else if (status.no_slot) begin
                    cmd.set_bang = 1'b1;
                    state_next   = ST_ECHO;
                end else begin
                    cmd.take_slot = 1'b1;
                    if (status.is_ctrl_z) begin
                        cmd.clear_len = 1'b1;
                        state_next    = ST_END;
                    end else if (status.is_newline) begin
                        state_next = status.len_zero ? ST_END : ST_CHARS;
                    end else if (status.is_backspace) begin
                        if (!status.len_zero) begin
                            cmd.dec_len = 1'b1;
                            state_next  = ST_ECHO;
                        end else begin
                            state_next = ST_IDLE;
                        end
                    end else if (status.len_full) begin
                        // line full: commit empty line, then echo
                        cmd.clear_len = 1'b1;
                        state_next    = ST_END;
                    end else begin
                        cmd.store_char = 1'b1;
                        state_next     = ST_ECHO;
                    end
                end
            end
            ST_CHARS: begin
                if (status.out_free) begin
                    cmd.load_char = 1'b1;
                    if (status.char_last) begin
                        state_next = ST_END;
                    end
                end
            end
            ST_END: begin
                cmd.end_last = !is_other;
                if (status.out_free) begin
                    cmd.load_end = 1'b1;
                    state_next   = is_other ? ST_ECHO : ST_IDLE;
                end
            end
            ST_ECHO: begin
                if (status.out_free) begin
                    cmd.load_echo = 1'b1;
                    state_next    = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

`ifndef SYNTH
    // A captured transfer always moves the controller to decode
    a_capture_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.capture |=> (state_reg == ST_DECODE))
        else $error("capture did not lead to decode");

    // Result loads only happen when the output register can take them
    a_load_free: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.load_char || cmd.load_end || cmd.load_echo) |-> status.out_free)
        else $error("result loaded into a busy output register");

    // Line character streaming always ends in a line end
    a_chars_to_end: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.load_char && status.char_last) |=> (state_reg == ST_END))
        else $error("character stream not followed by line end");
`endif

endmodule

// File: rtl/sle_dp.sv
module sle_dp
    import sle_pkg::*;
#(
    parameter int LINE_BYTES = LINE_BYTES_DEF,
    parameter int POOL_SLOTS = POOL_SLOTS_DEF
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_action,
    input  logic [BYTE_W-1:0]    s_rx_byte,
    output logic                 m_valid,
    input  logic                 m_ready,
    output logic [KIND_W-1:0]    m_kind,
    output logic [BYTE_W-1:0]    m_out_byte,
    output logic [LEN_OUT_W-1:0] m_line_length,
    output logic                 m_last,
    input  cmd_t                 cmd,
    output status_t              status
);

    localparam int STORE_DEPTH = LINE_BYTES - 1;
    localparam int AW          = addr_w(STORE_DEPTH);
    localparam int CW          = $clog2(LINE_BYTES);
    localparam int PW          = $clog2(POOL_SLOTS + 1);

    // Captured input
    logic                 action_reg;
    logic [BYTE_W-1:0]    byte_reg;
    logic                 bang_reg;
    logic                 bang_next;

    // Line and pool state
    logic [CW-1:0]        len_reg;
    logic [CW-1:0]        len_next;
    logic [CW-1:0]        idx_reg;
    logic [CW-1:0]        idx_next;
    logic [CW-1:0]        idx_plus;
    logic [PW-1:0]        pending_reg;
    logic [PW-1:0]        pending_next;
    logic                 held_reg;
    logic                 held_next;

    // Output register
    logic                 m_valid_reg;
    logic                 m_valid_next;
    logic [KIND_W-1:0]    kind_reg;
    logic [KIND_W-1:0]    kind_next;
    logic [BYTE_W-1:0]    out_byte_reg;
    logic [BYTE_W-1:0]    out_byte_next;
    logic [LEN_OUT_W-1:0] length_reg;
    logic [LEN_OUT_W-1:0] length_next;
    logic                 last_reg;
    logic                 last_next;

    logic                 out_free;
    logic                 load_any;
    logic [CW+LEN_OUT_W-1:0] len_wide;
    logic [AW-1:0]        rd_addr;
    logic [BYTE_W-1:0]    rd_data;

    // Line store
    sle_ram #(
        .WIDTH (BYTE_W),
        .DEPTH (STORE_DEPTH)
    ) u_store (
        .aclk    (aclk),
        .wr_en   (cmd.store_char),
        .wr_addr (len_reg[AW-1:0]),
        .wr_data (byte_reg),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    assign idx_plus = idx_reg + CW'(1);

    // Read ahead so one character leaves per cycle while the output register is free
    assign rd_addr = (cmd.load_char && !status.char_last) ? idx_plus[AW-1:0]
                                                           : idx_reg[AW-1:0];

    assign out_free = !m_valid_reg || m_ready;
    assign load_any = cmd.load_char || cmd.load_end || cmd.load_echo;
    assign len_wide = {{LEN_OUT_W{1'b0}}, len_reg};

    // Status to controller
    always_comb begin
        status              = '0;
        status.is_release   = (action_reg == ACT_RELEASE);
        status.no_slot      = !held_reg && (pending_reg == PW'(POOL_SLOTS));
        status.is_ctrl_z    = (byte_reg == CH_CTRL_Z);
        status.is_newline   = (byte_reg == CH_NEWLINE);
        status.is_backspace = (byte_reg == CH_BACKSPACE);
        status.len_zero     = (len_reg == '0);
        status.len_full     = (len_reg == CW'(LINE_BYTES - 1));
        status.char_last    = (idx_plus == len_reg);
        status.out_free     = out_free;
    end

    // Next state of line and pool
    always_comb begin
        len_next     = len_reg;
        idx_next     = idx_reg;
        pending_next = pending_reg;
        held_next    = held_reg;
        bang_next    = bang_reg;

        if (cmd.capture) begin
            bang_next = 1'b0;
        end
        if (cmd.set_bang) begin
            bang_next = 1'b1;
        end
        if (cmd.dec_pending && (pending_reg != '0)) begin
            pending_next = pending_reg - PW'(1);
        end
        if (cmd.take_slot) begin
            held_next = 1'b1;
        end
        if (cmd.clear_len) begin
            len_next = '0;
        end else if (cmd.dec_len) begin
            len_next = len_reg - CW'(1);
        end else if (cmd.store_char) begin
            len_next = len_reg + CW'(1);
        end
        if (cmd.load_char) begin
            idx_next = idx_plus;
        end
        // commit frees the slot to the pending pool
        if (cmd.load_end) begin
            len_next     = '0;
            idx_next     = '0;
            held_next    = 1'b0;
            pending_next = pending_reg + PW'(1);
        end
    end

    // Next output register
    always_comb begin
        m_valid_next  = m_valid_reg && !m_ready;
        kind_next     = kind_reg;
        out_byte_next = out_byte_reg;
        length_next   = length_reg;
        last_next     = last_reg;
        if (load_any) begin
            m_valid_next = 1'b1;
        end
        if (cmd.load_char) begin
            kind_next     = KIND_CHAR;
            out_byte_next = rd_data;
            length_next   = '0;
            last_next     = 1'b0;
        end else if (cmd.load_end) begin
            kind_next     = KIND_END;
            out_byte_next = '0;
            length_next   = len_wide[LEN_OUT_W-1:0];
            last_next     = cmd.end_last;
        end else if (cmd.load_echo) begin
            kind_next     = KIND_ECHO;
            out_byte_next = bang_reg ? CH_BANG : byte_reg;
            length_next   = '0;
            last_next     = 1'b1;
        end
    end

    // Control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            len_reg     <= '0;
            idx_reg     <= '0;
            pending_reg <= '0;
            held_reg    <= 1'b0;
            bang_reg    <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            len_reg     <= len_next;
            idx_reg     <= idx_next;
            pending_reg <= pending_next;
            held_reg    <= held_next;
            bang_reg    <= bang_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            action_reg <= s_action;
            byte_reg   <= s_rx_byte;
        end
        kind_reg     <= kind_next;
        out_byte_reg <= out_byte_next;
        length_reg   <= length_next;
        last_reg     <= last_next;
    end

    assign m_valid       = m_valid_reg;
    assign m_kind        = kind_reg;
    assign m_out_byte    = out_byte_reg;
    assign m_line_length = length_reg;
    assign m_last        = last_reg;

`ifndef SYNTH
    // Pool credit never exceeds the number of slots
    a_pending_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        pending_reg <= PW'(POOL_SLOTS))
        else $error("pending lines above pool size");

    // No characters stored unless a slot is held
    a_len_needs_slot: assert property (@(posedge aclk) disable iff (!aresetn)
        !held_reg |-> (len_reg == '0))
        else $error("characters stored without a slot");

    // Streaming never reads past the stored line
    a_idx_in_line: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.load_char |-> (idx_reg < len_reg))
        else $error("line character read beyond line length");

    // A line end releases the slot and resets the line
    a_end_frees: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.load_end |=> (!held_reg && (len_reg == '0) && (idx_reg == '0)))
        else $error("line end did not release the slot");
`endif

endmodule

// File: rtl/serial_line_editor.sv
// Line editor for received serial bytes, with backspace.
//
// Input channel (s_valid/s_ready): one transfer per received byte
// (s_action = 0) or per line slot released by the consumer (s_action = 1).
// Result channel (m_valid/m_ready): echo bytes, committed line characters
// and a line end carrying the length; m_last marks the final result that
// one input transfer causes.
//
// Sequencing: an input transfer is captured in ST_IDLE and decoded in
// ST_DECODE; the first result is then loaded into the output register
// from ST_CHARS, ST_END or ST_ECHO once the register is free. A commit
// of N stored characters streams them one per cycle, while the receiver
// does not stall, out of the line store (registered read, prefetched one
// address ahead), followed by the line end; N is up to LINE_BYTES - 1.
//
// One item is in flight at a time; s_ready rises again once the last
// result has entered the output register, even while it waits on m_ready.
// A stalled receiver holds the output register and the controller waits.
// Reset empties the line, releases all slots and clears the output valid flag.
module serial_line_editor
    import sle_pkg::*;
#(
    parameter int LINE_BYTES = LINE_BYTES_DEF,
    parameter int POOL_SLOTS = POOL_SLOTS_DEF
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  logic                 s_action,
    input  logic [BYTE_W-1:0]    s_rx_byte,
    output logic                 m_valid,
    input  logic                 m_ready,
    output logic [KIND_W-1:0]    m_kind,
    output logic [BYTE_W-1:0]    m_out_byte,
    output logic [LEN_OUT_W-1:0] m_line_length,
    output logic                 m_last
);

    cmd_t    cmd;
    status_t status;

    sle_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .status  (status),
        .cmd     (cmd)
    );

    sle_dp #(
        .LINE_BYTES (LINE_BYTES),
        .POOL_SLOTS (POOL_SLOTS)
    ) u_dp (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_action      (s_action),
        .s_rx_byte     (s_rx_byte),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_kind        (m_kind),
        .m_out_byte    (m_out_byte),
        .m_line_length (m_line_length),
        .m_last        (m_last),
        .cmd           (cmd),
        .status        (status)
    );

endmodule

// File: tb/sv/tb_top.sv
`timescale 1ns / 1ps

import sle_pkg::*;

typedef struct packed {
    logic [KIND_W-1:0]    kind;
    logic [BYTE_W-1:0]    out_byte;
    logic [LEN_OUT_W-1:0] line_length;
    logic                 last;
} editor_result_t;

// Scoreboard: tracks the editor state and holds the expected result stream
class line_editor_sb;
    localparam int MAX_CHARS = LINE_BYTES_DEF - 1;
    localparam int SLOTS     = POOL_SLOTS_DEF;

    editor_result_t    expected_q[$];
    editor_result_t    item_q[$];
    logic [BYTE_W-1:0] line_chars [MAX_CHARS];
    int                line_len;
    bit                slot_held;
    int                pending;

    int errors;
    int n_items;
    int n_results;
    int n_lines;
    int n_full;
    int n_empty;
    int n_bang;

    function new();
        line_len  = 0;
        slot_held = 1'b0;
        pending   = 0;
        errors    = 0;
        n_items   = 0;
        n_results = 0;
        n_lines   = 0;
        n_full    = 0;
        n_empty   = 0;
        n_bang    = 0;
    endfunction

    function int lines_pending();
        return pending;
    endfunction

    function bit drained();
        return expected_q.size() == 0;
    endfunction

    function void add_result(logic [KIND_W-1:0] k, logic [BYTE_W-1:0] b,
                             logic [LEN_OUT_W-1:0] l);
        editor_result_t r;
        r.kind        = k;
        r.out_byte    = b;
        r.line_length = l;
        r.last        = 1'b0;
        item_q.push_back(r);
    endfunction

    // Stream the stored characters, then the line end with the length
    function void commit_line();
        for (int i = 0; i < line_len; i++)
            add_result(KIND_CHAR, line_chars[i], '0);
        add_result(KIND_END, '0, LEN_OUT_W'(line_len));
        n_lines++;
        if (line_len == MAX_CHARS) n_full++;
        if (line_len == 0) n_empty++;
        pending++;
        slot_held = 1'b0;
        line_len  = 0;
    endfunction

    // Called once per accepted input transfer
    function void note_item(logic act, logic [BYTE_W-1:0] rx);
        item_q.delete();
        n_items++;
        if (act == ACT_RELEASE) begin
            if (pending > 0) pending--;
            return;
        end
        if (!slot_held && pending >= SLOTS) begin
            // pool exhausted: drop the byte
            add_result(KIND_ECHO, CH_BANG, '0);
            n_bang++;
        end else begin
            if (!slot_held) begin
                slot_held = 1'b1;
                line_len  = 0;
            end
            if (rx == CH_CTRL_Z) begin
                line_len = 0;
                commit_line();
            end else if (rx == CH_NEWLINE) begin
                commit_line();
            end else if (rx == CH_BACKSPACE) begin
                if (line_len > 0) begin
                    line_len--;
                    add_result(KIND_ECHO, rx, '0);
                end
            end else begin
                if (line_len >= MAX_CHARS) begin
                    // line full: commit an empty line, echo without storing
                    line_len = 0;
                    commit_line();
                end else begin
                    line_chars[line_len] = rx;
                    line_len++;
                end
                add_result(KIND_ECHO, rx, '0);
            end
        end
        if (item_q.size() > 0) item_q[item_q.size() - 1].last = 1'b1;
        foreach (item_q[i]) expected_q.push_back(item_q[i]);
    endfunction

    // Called once per accepted result transfer
    function void check_result(logic [KIND_W-1:0] k, logic [BYTE_W-1:0] b,
                               logic [LEN_OUT_W-1:0] l, logic lst);
        editor_result_t e;
        n_results++;
        if (expected_q.size() == 0) begin
            $error("unexpected result: kind %0d byte 0x%02h length %0d last %0b",
                   k, b, l, lst);
            errors++;
            return;
        end
        e = expected_q.pop_front();
        if (k !== e.kind) begin
            $error("kind mismatch: expected %0d, actual %0d", e.kind, k);
            errors++;
        end
        if (b !== e.out_byte) begin
            $error("out_byte mismatch: expected 0x%02h, actual 0x%02h", e.out_byte, b);
            errors++;
        end
        if (l !== e.line_length) begin
            $error("line_length mismatch: expected %0d, actual %0d", e.line_length, l);
            errors++;
        end
        if (lst !== e.last) begin
            $error("last mismatch: expected %0b, actual %0b", e.last, lst);
            errors++;
        end
    endfunction
endclass

module tb_top;

    localparam int LINE_BYTES   = LINE_BYTES_DEF;
    localparam int POOL_SLOTS   = POOL_SLOTS_DEF;
    localparam int RANDOM_ITEMS = 160;
    localparam int STALL_LIMIT  = 2000;
    localparam int TAIL_CYCLES  = 40;

    typedef enum logic [1:0] {
        RX_FREE,
        RX_COIN,
        RX_SLOW,
        RX_PERIODIC
    } rx_mode_t;

    logic                 aclk      = 1'b0;
    logic                 aresetn   = 1'b0;
    logic                 s_valid   = 1'b0;
    logic                 s_ready;
    logic                 s_action  = ACT_BYTE;
    logic [BYTE_W-1:0]    s_rx_byte = '0;
    logic                 m_valid;
    logic                 m_ready   = 1'b0;
    logic [KIND_W-1:0]    m_kind;
    logic [BYTE_W-1:0]    m_out_byte;
    logic [LEN_OUT_W-1:0] m_line_length;
    logic                 m_last;

    rx_mode_t    stall_mode = RX_FREE;
    logic [15:0] stall_cnt  = '0;

    line_editor_sb sb = new();

    int burst_left   = 0;
    int useful_items = 0;

    serial_line_editor #(
        .LINE_BYTES(LINE_BYTES),
        .POOL_SLOTS(POOL_SLOTS)
    ) dut (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_action     (s_action),
        .s_rx_byte    (s_rx_byte),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_kind       (m_kind),
        .m_out_byte   (m_out_byte),
        .m_line_length(m_line_length),
        .m_last       (m_last)
    );

    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    // Receiver backpressure: random mode, re-picked when the low six counter bits reach 63
    always @(posedge aclk) begin
        stall_cnt <= stall_cnt + 16'd1;
        if (stall_cnt[5:0] == 6'd63) stall_mode <= rx_mode_t'($urandom_range(0, 3));
        case (stall_mode)
            RX_FREE:     m_ready <= 1'b1;
            RX_COIN:     m_ready <= 1'($urandom_range(0, 1));
            RX_SLOW:     m_ready <= ($urandom_range(0, 3) == 0);
            RX_PERIODIC: m_ready <= (stall_cnt[2:0] != 3'd0) && (stall_cnt[2:0] != 3'd5);
            default:     m_ready <= 1'b1;
        endcase
    end

    // Result monitor
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready)
            sb.check_result(m_kind, m_out_byte, m_line_length, m_last);
    end

    // Watchdog on cycles without any transfer
    initial begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < STALL_LIMIT) begin
            @(posedge aclk);
            if ((s_valid && s_ready) || (m_valid && m_ready)) quiet = 0;
            else quiet++;
        end
        $display("watchdog: no transfer for %0d cycles", quiet);
        $display("*** FAILED ***");
        $finish;
    end

    function automatic logic [BYTE_W-1:0] text_byte();
        logic [BYTE_W-1:0] b;
        b = 8'($urandom_range(0, 255));
        while (b == CH_CTRL_Z || b == CH_NEWLINE || b == CH_BACKSPACE)
            b = 8'($urandom_range(0, 255));
        return b;
    endfunction

    task automatic idle_for(input int n);
        s_valid <= 1'b0;
        repeat (n) @(posedge aclk);
    endtask

    // Drive one input transfer, then apply burst/gap pacing
    task automatic put_item(input logic act, input logic [BYTE_W-1:0] b);
        int gap;
        if (!(act == ACT_RELEASE && sb.lines_pending() == 0)) useful_items++;
        s_valid   <= 1'b1;
        s_action  <= act;
        s_rx_byte <= b;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        sb.note_item(act, b);
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? $urandom_range(10, 40) : $urandom_range(1, 6);
            idle_for(gap);
            burst_left = $urandom_range(1, 8);
        end else begin
            burst_left--;
        end
    endtask

    task automatic wait_drained();
        s_valid <= 1'b0;
        do @(posedge aclk); while (!sb.drained());
    endtask

    // One edited line: characters with stray backspaces, optional overflow,
    // then newline, Ctrl-Z or nothing at all
    task automatic type_line(input int n_chars, input bit overflow, input int ending);
        for (int i = 0; i < n_chars; i++) begin
            if ($urandom_range(0, 5) == 0) put_item(ACT_BYTE, CH_BACKSPACE);
            put_item(ACT_BYTE, text_byte());
        end
        if (overflow) put_item(ACT_BYTE, text_byte());
        case (ending)
            0:       put_item(ACT_BYTE, CH_NEWLINE);
            1:       put_item(ACT_BYTE, CH_CTRL_Z);
            default: ;
        endcase
    endtask

    initial begin : stimulus
        int base;
        int pick;
        int ending;
        bit paused;

        paused = 1'b0;
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed: release with nothing pending, commits, backspace cases
        put_item(ACT_RELEASE, 8'hFF);
        put_item(ACT_BYTE, CH_CTRL_Z);
        put_item(ACT_BYTE, CH_BACKSPACE);
        put_item(ACT_BYTE, 8'h00);
        put_item(ACT_BYTE, CH_BACKSPACE);
        put_item(ACT_BYTE, 8'hFF);
        put_item(ACT_BYTE, CH_NEWLINE);
        // both slots committed: no free slot
        put_item(ACT_BYTE, 8'h78);
        put_item(ACT_RELEASE, 8'h00);
        put_item(ACT_RELEASE, 8'hA5);
        // fill the line, then one more byte
        for (int i = 0; i < LINE_BYTES - 1; i++) put_item(ACT_BYTE, text_byte());
        put_item(ACT_BYTE, 8'h7F);
        put_item(ACT_RELEASE, 8'h5A);
        wait_drained();

        // Random: mostly well-formed lines, some releases and noise
        base = useful_items;
        while (useful_items - base < RANDOM_ITEMS) begin
            if (!paused && useful_items - base >= RANDOM_ITEMS / 2) begin
                wait_drained();
                paused = 1'b1;
            end
            pick = $urandom_range(0, 19);
            if (sb.lines_pending() >= POOL_SLOTS && $urandom_range(0, 4) != 0)
                put_item(ACT_RELEASE, text_byte());
            if (pick < 14) begin
                ending = ($urandom_range(0, 19) < 9) ? 0 : ($urandom_range(0, 10) < 7 ? 1 : 2);
                case ($urandom_range(0, 9))
                    7:       type_line(LINE_BYTES - 1, 1'b0, 0);
                    8:       type_line(LINE_BYTES - 1, 1'b1, ending);
                    9:       type_line($urandom_range(7, LINE_BYTES - 2), 1'b0, ending);
                    default: type_line($urandom_range(0, 6), 1'b0, ending);
                endcase
            end else if (pick < 17) begin
                put_item(ACT_RELEASE, 8'($urandom_range(0, 255)));
            end else begin
                put_item(1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)));
            end
        end

        // Drain and let the block settle
        wait_drained();
        repeat (TAIL_CYCLES) @(posedge aclk);

        $display("Run covered %0d input transfers and %0d results: %0d lines committed",
                 sb.n_items, sb.n_results, sb.n_lines);
        $display("(%0d at full length, %0d empty), %0d bytes dropped with no free slot",
                 sb.n_full, sb.n_empty, sb.n_bang);
        if (sb.errors == 0 && sb.drained()) begin
            $display("*** PASSED ***");
        end else begin
            if (!sb.drained()) $error("%0d expected results never arrived", sb.expected_q.size());
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
